FILE: design/lens_distortion_map_macros.svh
// Assertion macros shared by the checkers of the lens distortion block.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef LENS_DISTORTION_MAP_MACROS_SVH
`define LENS_DISTORTION_MAP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define LDM_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ldm assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define LDM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ldm assertion failed");

`endif

FILE: design/ldm_pkg.sv
// Shared types, constants and saturating helpers for the lens distortion block.
// Depends on nothing; used by the interfaces, the multiplier and the top level.
`default_nettype none

package ldm_pkg;

	// Field and intermediate widths
	localparam int unsigned CW   = 32;  // coordinates, coefficients, focal, centre
	localparam int unsigned OW   = 40;  // pixel coordinate, Q24.16
	localparam int unsigned DW   = 64;  // configuration write data
	localparam int unsigned IW   = 61;  // intermediate value, magnitude below 2^60
	localparam int unsigned FRAC = 28;  // fraction bits of intermediates
	localparam int unsigned R2W  = 37;  // signed width that holds any r2 value

	typedef logic signed [IW-1:0] ival_t;
	typedef logic signed [OW-1:0] pix_t;

	typedef struct packed {
		logic  sat;
		ival_t v;
	} sval_t;

	typedef struct packed {
		logic sat;
		pix_t v;
	} pval_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_K1 = 3'd0,
		REG_K2 = 3'd1,
		REG_K3 = 3'd2,
		REG_P1 = 3'd3,
		REG_P2 = 3'd4,
		REG_FX = 3'd5,
		REG_FY = 3'd6,
		REG_PP = 3'd7
	} cfg_reg_t;

	localparam logic [CW-1:0] FOCAL_ONE = {{(CW-17){1'b0}}, 1'b1, 16'h0000};

	// Intermediate clip bounds and the unit value of the radial gain
	localparam ival_t LIM   = {1'b0, {(IW-1){1'b1}}};
	localparam ival_t NLIM  = -LIM;
	localparam ival_t ONE_Q = {{(IW-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};

	localparam logic signed [IW:0] SUM_MAX = {2'b00, {(IW-1){1'b1}}};
	localparam logic signed [IW:0] SUM_MIN = -SUM_MAX;
	localparam logic signed [IW:0] PIX_MAX = {{(IW+2-OW){1'b0}}, {(OW-1){1'b1}}};
	localparam logic signed [IW:0] PIX_MIN = {{(IW+2-OW){1'b1}}, {(OW-1){1'b0}}};

	// Saturating add of two intermediates
	function automatic sval_t sat_add(input ival_t a, input ival_t b);
		logic signed [IW:0] s;
		sval_t r;
		s = $signed({a[IW-1], a}) + $signed({b[IW-1], b});
		r.sat = 1'b0;
		r.v   = s[IW-1:0];
		if (s > SUM_MAX) begin
			r.sat = 1'b1;
			r.v   = LIM;
		end else if (s < SUM_MIN) begin
			r.sat = 1'b1;
			r.v   = NLIM;
		end
		return r;
	endfunction

	// Add the principal point and clip to the pixel range
	function automatic pval_t pix_clip(input ival_t m, input logic [CW-1:0] c);
		logic signed [IW:0] s;
		pval_t r;
		s = $signed({m[IW-1], m}) + $signed({{(IW+1-CW){1'b0}}, c});
		r.sat = 1'b0;
		r.v   = s[OW-1:0];
		if (s > PIX_MAX) begin
			r.sat = 1'b1;
			r.v   = PIX_MAX[OW-1:0];
		end else if (s < PIX_MIN) begin
			r.sat = 1'b1;
			r.v   = PIX_MIN[OW-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: design/ldm_ifs.sv
// Valid/ready channel interfaces for the point input and the pixel output.
// Depends on ldm_pkg for the field widths.
`default_nettype none

interface ldm_in_if;
	logic                            valid;
	logic                            ready;
	logic signed [ldm_pkg::CW-1:0]   norm_x;
	logic signed [ldm_pkg::CW-1:0]   norm_y;

	modport source (output valid, output norm_x, output norm_y, input ready);
	modport sink (input valid, input norm_x, input norm_y, output ready);
endinterface

interface ldm_out_if;
	logic                  valid;
	logic                  ready;
	ldm_pkg::pix_t         pixel_x;
	ldm_pkg::pix_t         pixel_y;
	logic                  saturated;

	modport source (output valid, output pixel_x, output pixel_y, output saturated,
		input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input saturated,
		output ready);
endinterface

`default_nettype wire

FILE: design/ldm_delay.sv
// Enabled shift line that carries side values alongside the pipeline.
// Depends on nothing; instantiated by lens_distortion_map.
`default_nettype none

module ldm_delay #(
	parameter int unsigned W = 1,
	parameter int unsigned D = 1
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);

	logic [W-1:0] line_q [D];

	// Advance the line by one place on every enabled cycle
	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < D; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign q = line_q[D-1];

endmodule

`default_nettype wire

FILE: design/ldm_mulq.sv
// Three-stage fixed-point multiplier: round(a*b / 2^28) half away from zero,
// clipped to +-(2^60-1). Depends on ldm_pkg; instantiated by lens_distortion_map.
`default_nettype none

module ldm_mulq #(
	parameter int unsigned AW = 32
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic signed [AW-1:0]  a,
	input  wire ldm_pkg::ival_t        b,
	output ldm_pkg::ival_t             res,
	output logic                       sat
);

	localparam int unsigned IW = ldm_pkg::IW;
	localparam int unsigned FR = ldm_pkg::FRAC;
	localparam int unsigned BL = 30;           // low slice of the wide operand
	localparam int unsigned PW = AW + IW + 1;  // product plus rounding carry

	localparam logic [PW-1:0] RND = {{(PW-FR){1'b0}}, 1'b1, {(FR-1){1'b0}}};

	logic [AW-1:0]    amag;
	logic [IW-1:0]    bmag;
	logic [AW+BL-1:0] pl_s1;
	logic [AW+IW-BL-1:0] ph_s1;
	logic             neg_s1;
	logic [PW-1:0]    sum_s2;
	logic             neg_s2;
	logic             over;
	logic [IW-2:0]    m;
	logic [IW-1:0]    mext;
	ldm_pkg::ival_t   res_s3;
	logic             sat_s3;

	// Sign and magnitude of both operands
	always_comb begin
		amag = a[AW-1] ? (~a + 1'b1) : a;
		bmag = b[IW-1] ? (~b + 1'b1) : b;
	end

	// Stage 1: two partial products over the split wide operand
	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1  <= {{BL{1'b0}}, amag} * {{AW{1'b0}}, bmag[BL-1:0]};
			ph_s1  <= {{(IW-BL){1'b0}}, amag} * {{AW{1'b0}}, bmag[IW-1:BL]};
			neg_s1 <= a[AW-1] ^ b[IW-1];
		end
	end

	// Stage 2: combine the partial products and add the rounding half
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= {{(PW-AW-BL){1'b0}}, pl_s1} + {1'b0, ph_s1, {BL{1'b0}}} + RND;
			neg_s2 <= neg_s1;
		end
	end

	// Stage 3: drop the fraction, clip the magnitude, restore the sign
	always_comb begin
		over = |sum_s2[PW-1:FR+IW-1];
		m    = over ? {(IW-1){1'b1}} : sum_s2[FR+IW-2:FR];
		mext = {1'b0, m};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3 <= neg_s2 ? -mext : mext;
			sat_s3 <= over;
		end
	end

	assign res = res_s3;
	assign sat = sat_s3;

endmodule

`default_nettype wire

FILE: design/lens_distortion_map.sv
// Each accepted point flows through the pipeline to its pixel on the output register.
// Throughput: one point per cycle while the skid stage is empty; six multiply phases of
// three stages, each followed by saturating add or clip stages, all advance together.
// Backpressure: a one-beat skid stage takes the beat in flight; input held only while full.
// Reset: arst_n clears all valid bits and loads the register defaults.
// Depends on ldm_pkg, ldm_ifs, ldm_delay and ldm_mulq.
`default_nettype none

module lens_distortion_map (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_wr_en,
	input  wire logic [2:0]               cfg_index,
	input  wire logic [ldm_pkg::DW-1:0]   cfg_data,
	ldm_in_if.sink                        in_ch,
	ldm_out_if.source                     out_ch
);

	localparam int unsigned CW    = ldm_pkg::CW;
	localparam int unsigned IW    = ldm_pkg::IW;
	localparam int unsigned R2W   = ldm_pkg::R2W;
	localparam int unsigned DEPTH = 24;

	// Configuration registers
	logic signed [CW-1:0] k1_q, k2_q, k3_q, p1_q, p2_q;
	logic [CW-1:0]        fx_q, fy_q;
	logic [2*CW-1:0]      pp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k1_q <= '0;
			k2_q <= '0;
			k3_q <= '0;
			p1_q <= '0;
			p2_q <= '0;
			fx_q <= ldm_pkg::FOCAL_ONE;
			fy_q <= ldm_pkg::FOCAL_ONE;
			pp_q <= '0;
		end else if (cfg_wr_en) begin
			case (ldm_pkg::cfg_reg_t'(cfg_index))
				ldm_pkg::REG_K1: k1_q <= cfg_data[CW-1:0];
				ldm_pkg::REG_K2: k2_q <= cfg_data[CW-1:0];
				ldm_pkg::REG_K3: k3_q <= cfg_data[CW-1:0];
				ldm_pkg::REG_P1: p1_q <= cfg_data[CW-1:0];
				ldm_pkg::REG_P2: p2_q <= cfg_data[CW-1:0];
				ldm_pkg::REG_FX: fx_q <= cfg_data[CW-1:0];
				ldm_pkg::REG_FY: fy_q <= cfg_data[CW-1:0];
				ldm_pkg::REG_PP: pp_q <= cfg_data[2*CW-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline enable and valid bits
	logic             en;
	logic             acc;
	logic [DEPTH-1:0] vld_q;
	logic             emit;
	logic             skid_vld_q;
	logic             out_vld_q;

	assign en          = !skid_vld_q;
	assign in_ch.ready = en;
	assign acc         = in_ch.valid && en;
	assign emit        = en && vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], acc};
		end
	end

	// Input point, sign-extended for the multipliers
	logic signed [CW-1:0] x0, y0;
	ldm_pkg::ival_t       x0e, y0e;

	assign x0  = in_ch.norm_x;
	assign y0  = in_ch.norm_y;
	assign x0e = ldm_pkg::ival_t'(x0);
	assign y0e = ldm_pkg::ival_t'(y0);

	// Carry the point to the x*g / y*g phase
	logic [2*CW-1:0]      xy_d16;
	logic signed [CW-1:0] x_d16, y_d16;

	ldm_delay #(.W(2*CW), .D(16)) u_dly_xy (
		.clk(clk), .en(en), .d({x0, y0}), .q(xy_d16)
	);
	assign x_d16 = xy_d16[2*CW-1:CW];
	assign y_d16 = xy_d16[CW-1:0];

	// Phase 1: xx, yy, xy
	ldm_pkg::ival_t xx_m, yy_m, xy_m;
	logic           xx_sat, yy_sat, xy_sat;

	ldm_mulq #(.AW(CW)) u_mul_xx (
		.clk(clk), .en(en), .a(x0), .b(x0e), .res(xx_m), .sat(xx_sat)
	);
	ldm_mulq #(.AW(CW)) u_mul_yy (
		.clk(clk), .en(en), .a(y0), .b(y0e), .res(yy_m), .sat(yy_sat)
	);
	ldm_mulq #(.AW(CW)) u_mul_xy (
		.clk(clk), .en(en), .a(x0), .b(y0e), .res(xy_m), .sat(xy_sat)
	);

	// Add stage 1: r2 and the doubled terms
	ldm_pkg::sval_t r2_a, xx2_a, yy2_a, xy2_a;
	ldm_pkg::ival_t r2_s4, xx2_s4, yy2_s4, xy2_s4;
	logic           sat_s4;

	always_comb begin
		r2_a  = ldm_pkg::sat_add(xx_m, yy_m);
		xx2_a = ldm_pkg::sat_add(xx_m, xx_m);
		yy2_a = ldm_pkg::sat_add(yy_m, yy_m);
		xy2_a = ldm_pkg::sat_add(xy_m, xy_m);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s4  <= r2_a.v;
			xx2_s4 <= xx2_a.v;
			yy2_s4 <= yy2_a.v;
			xy2_s4 <= xy2_a.v;
			sat_s4 <= xx_sat | yy_sat | xy_sat | r2_a.sat | xx2_a.sat | yy2_a.sat
				| xy2_a.sat;
		end
	end

	logic [3*IW:0]  a1_d7;
	logic           sat_d7;
	ldm_pkg::ival_t r2_d7, xx2_d7, yy2_d7;

	ldm_delay #(.W(3*IW+1), .D(3)) u_dly_a1 (
		.clk(clk), .en(en), .d({sat_s4, r2_s4, xx2_s4, yy2_s4}), .q(a1_d7)
	);
	assign {sat_d7, r2_d7, xx2_d7, yy2_d7} = a1_d7;

	// Phase 2: r4, k1*r2, p1*xy2, p2*xy2
	ldm_pkg::ival_t r4_m, k1r2_m, p1xy_m, p2xy_m;
	logic           r4_sat, k1r2_sat, p1xy_sat, p2xy_sat;

	ldm_mulq #(.AW(R2W)) u_mul_r4 (
		.clk(clk), .en(en), .a(r2_s4[R2W-1:0]), .b(r2_s4), .res(r4_m), .sat(r4_sat)
	);
	ldm_mulq #(.AW(CW)) u_mul_k1r2 (
		.clk(clk), .en(en), .a(k1_q), .b(r2_s4), .res(k1r2_m), .sat(k1r2_sat)
	);
	ldm_mulq #(.AW(CW)) u_mul_p1xy (
		.clk(clk), .en(en), .a(p1_q), .b(xy2_s4), .res(p1xy_m), .sat(p1xy_sat)
	);
	ldm_mulq #(.AW(CW)) u_mul_p2xy (
		.clk(clk), .en(en), .a(p2_q), .b(xy2_s4), .res(p2xy_m), .sat(p2xy_sat)
	);

	// Hold the tangential cross terms until the xd / yd sums
	logic [2*IW-1:0] txy_d19;
	ldm_pkg::ival_t  p1xy_d19, p2xy_d19;

	ldm_delay #(.W(2*IW), .D(12)) u_dly_txy (
		.clk(clk), .en(en), .d({p1xy_m, p2xy_m}), .q(txy_d19)
	);
	assign {p1xy_d19, p2xy_d19} = txy_d19;

	// Add stage 2: first gain term and the tangential radial terms
	ldm_pkg::sval_t g1_a, rx_a, ry_a;
	ldm_pkg::ival_t g1_s8, rx_s8, ry_s8, r2_s8, r4_s8;
	logic           sat_s8;

	always_comb begin
		g1_a = ldm_pkg::sat_add(ldm_pkg::ONE_Q, k1r2_m);
		rx_a = ldm_pkg::sat_add(r2_d7, xx2_d7);
		ry_a = ldm_pkg::sat_add(r2_d7, yy2_d7);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g1_s8  <= g1_a.v;
			rx_s8  <= rx_a.v;
			ry_s8  <= ry_a.v;
			r2_s8  <= r2_d7;
			r4_s8  <= r4_m;
			sat_s8 <= sat_d7 | r4_sat | k1r2_sat | p1xy_sat | p2xy_sat | g1_a.sat
				| rx_a.sat | ry_a.sat;
		end
	end

	logic [IW:0]    a2_d11;
	logic           sat_d11;
	ldm_pkg::ival_t g1_d11;

	ldm_delay #(.W(IW+1), .D(3)) u_dly_a2 (
		.clk(clk), .en(en), .d({sat_s8, g1_s8}), .q(a2_d11)
	);
	assign {sat_d11, g1_d11} = a2_d11;

	// Phase 3: r6, k2*r4, p2*rx, p1*ry
	ldm_pkg::ival_t r6_m, k2r4_m, p2rx_m, p1ry_m;
	logic           r6_sat, k2r4_sat, p2rx_sat, p1ry_sat;

	ldm_mulq #(.AW(R2W)) u_mul_r6 (
		.clk(clk), .en(en), .a(r2_s8[R2W-1:0]), .b(r4_s8), .res(r6_m), .sat(r6_sat)
	);
	ldm_mulq #(.AW(CW)) u_mul_k2r4 (
		.clk(clk), .en(en), .a(k2_q), .b(r4_s8), .res(k2r4_m), .sat(k2r4_sat)
	);
	ldm_mulq #(.AW(CW)) u_mul_p2rx (
		.clk(clk), .en(en), .a(p2_q), .b(rx_s8), .res(p2rx_m), .sat(p2rx_sat)
	);
	ldm_mulq #(.AW(CW)) u_mul_p1ry (
		.clk(clk), .en(en), .a(p1_q), .b(ry_s8), .res(p1ry_m), .sat(p1ry_sat)
	);

	// Hold the tangential radial products until the last xd / yd sum
	logic [2*IW-1:0] trr_d20;
	ldm_pkg::ival_t  p2rx_d20, p1ry_d20;

	ldm_delay #(.W(2*IW), .D(9)) u_dly_trr (
		.clk(clk), .en(en), .d({p2rx_m, p1ry_m}), .q(trr_d20)
	);
	assign {p2rx_d20, p1ry_d20} = trr_d20;

	// Add stage 3: second gain term
	ldm_pkg::sval_t g2_a;
	ldm_pkg::ival_t g2_s12, r6_s12;
	logic           sat_s12;

	assign g2_a = ldm_pkg::sat_add(g1_d11, k2r4_m);

	always_ff @(posedge clk) begin
		if (en) begin
			g2_s12  <= g2_a.v;
			r6_s12  <= r6_m;
			sat_s12 <= sat_d11 | r6_sat | k2r4_sat | p2rx_sat | p1ry_sat | g2_a.sat;
		end
	end

	logic [IW:0]    a3_d15;
	logic           sat_d15;
	ldm_pkg::ival_t g2_d15;

	ldm_delay #(.W(IW+1), .D(3)) u_dly_a3 (
		.clk(clk), .en(en), .d({sat_s12, g2_s12}), .q(a3_d15)
	);
	assign {sat_d15, g2_d15} = a3_d15;

	// Phase 4: k3*r6
	ldm_pkg::ival_t k3r6_m;
	logic           k3r6_sat;

	ldm_mulq #(.AW(CW)) u_mul_k3r6 (
		.clk(clk), .en(en), .a(k3_q), .b(r6_s12), .res(k3r6_m), .sat(k3r6_sat)
	);

	// Add stage 4: full radial gain
	ldm_pkg::sval_t g_a;
	ldm_pkg::ival_t g_s16;
	logic           sat_s16;

	assign g_a = ldm_pkg::sat_add(g2_d15, k3r6_m);

	always_ff @(posedge clk) begin
		if (en) begin
			g_s16   <= g_a.v;
			sat_s16 <= sat_d15 | k3r6_sat | g_a.sat;
		end
	end

	logic sat_d19;

	ldm_delay #(.W(1), .D(3)) u_dly_a4 (
		.clk(clk), .en(en), .d(sat_s16), .q(sat_d19)
	);

	// Phase 5: x*g, y*g
	ldm_pkg::ival_t xg_m, yg_m;
	logic           xg_sat, yg_sat;

	ldm_mulq #(.AW(CW)) u_mul_xg (
		.clk(clk), .en(en), .a(x_d16), .b(g_s16), .res(xg_m), .sat(xg_sat)
	);
	ldm_mulq #(.AW(CW)) u_mul_yg (
		.clk(clk), .en(en), .a(y_d16), .b(g_s16), .res(yg_m), .sat(yg_sat)
	);

	// Add stage 5a: add the cross terms
	ldm_pkg::sval_t xd1_a, yd1_a;
	ldm_pkg::ival_t xd1_s20, yd1_s20;
	logic           sat_s20;

	always_comb begin
		xd1_a = ldm_pkg::sat_add(xg_m, p1xy_d19);
		yd1_a = ldm_pkg::sat_add(yg_m, p2xy_d19);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xd1_s20 <= xd1_a.v;
			yd1_s20 <= yd1_a.v;
			sat_s20 <= sat_d19 | xg_sat | yg_sat | xd1_a.sat | yd1_a.sat;
		end
	end

	// Add stage 5b: add the radial tangential terms
	ldm_pkg::sval_t xd_a, yd_a;
	ldm_pkg::ival_t xd_s21, yd_s21;
	logic           sat_s21;

	always_comb begin
		xd_a = ldm_pkg::sat_add(xd1_s20, p2rx_d20);
		yd_a = ldm_pkg::sat_add(yd1_s20, p1ry_d20);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xd_s21  <= xd_a.v;
			yd_s21  <= yd_a.v;
			sat_s21 <= sat_s20 | xd_a.sat | yd_a.sat;
		end
	end

	logic sat_d24;

	ldm_delay #(.W(1), .D(3)) u_dly_a5 (
		.clk(clk), .en(en), .d(sat_s21), .q(sat_d24)
	);

	// Phase 6: scale by the focal lengths
	ldm_pkg::ival_t fxd_m, fyd_m;
	logic           fxd_sat, fyd_sat;

	ldm_mulq #(.AW(CW+1)) u_mul_fx (
		.clk(clk), .en(en), .a({1'b0, fx_q}), .b(xd_s21), .res(fxd_m), .sat(fxd_sat)
	);
	ldm_mulq #(.AW(CW+1)) u_mul_fy (
		.clk(clk), .en(en), .a({1'b0, fy_q}), .b(yd_s21), .res(fyd_m), .sat(fyd_sat)
	);

	// Add the principal point and clip to the pixel range
	ldm_pkg::pval_t px_a, py_a;
	logic           sat_fin;

	always_comb begin
		px_a    = ldm_pkg::pix_clip(fxd_m, pp_q[CW-1:0]);
		py_a    = ldm_pkg::pix_clip(fyd_m, pp_q[2*CW-1:CW]);
		sat_fin = sat_d24 | fxd_sat | fyd_sat | px_a.sat | py_a.sat;
	end

	// Output register and skid stage
	ldm_pkg::pix_t px_q, py_q, skid_px_q, skid_py_q;
	logic          sat_q, skid_sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || out_ch.ready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= emit;
			end
		end else if (emit) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || out_ch.ready) begin
			if (skid_vld_q) begin
				px_q  <= skid_px_q;
				py_q  <= skid_py_q;
				sat_q <= skid_sat_q;
			end else if (emit) begin
				px_q  <= px_a.v;
				py_q  <= py_a.v;
				sat_q <= sat_fin;
			end
		end else if (emit) begin
			skid_px_q  <= px_a.v;
			skid_py_q  <= py_a.v;
			skid_sat_q <= sat_fin;
		end
	end

	assign out_ch.valid     = out_vld_q;
	assign out_ch.pixel_x   = px_q;
	assign out_ch.pixel_y   = py_q;
	assign out_ch.saturated = sat_q;

endmodule

`default_nettype wire

FILE: design/ldm_checker.sv
// Port-level checker for the lens distortion block, bound to its top level.
// Depends on lens_distortion_map_macros.svh and ldm_pkg.
`default_nettype none

`include "lens_distortion_map_macros.svh"

module ldm_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_ready,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire ldm_pkg::pix_t pixel_x,
	input wire ldm_pkg::pix_t pixel_y,
	input wire logic          saturated
);

	logic [5:0] pend_q;
	logic       in_beat, out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// Count points accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_beat && !out_beat) begin
			pend_q <= pend_q + 6'd1;
		end else if (out_beat && !in_beat) begin
			pend_q <= pend_q - 6'd1;
		end
	end

	`LDM_ASSERT_NEXT(a_out_valid_held, clk, arst_n, out_valid && !out_ready, out_valid)
	`LDM_ASSERT_NEXT(a_out_beat_held, clk, arst_n, out_valid && !out_ready, $stable(pixel_x) && $stable(pixel_y) && $stable(saturated))
	`LDM_ASSERT_NOW(a_no_invented_beat, clk, arst_n, out_valid, pend_q != 6'd0)
	`LDM_ASSERT_NOW(a_ready_when_drained, clk, arst_n, !out_valid, in_ready)

endmodule

bind lens_distortion_map ldm_checker u_ldm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.pixel_x   (out_ch.pixel_x),
	.pixel_y   (out_ch.pixel_y),
	.saturated (out_ch.saturated)
);

`default_nettype wire
